// ----- sv/author_count_table_unit_defines.svh -----
// Assertion macros used by the checker of the author count table.
`ifndef AUTHOR_COUNT_TABLE_UNIT_DEFINES_SVH
`define AUTHOR_COUNT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define ACT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("author count table check failed");

// Next-cycle implication, sampled on i_clk and held off while i_rst_n is low.
`define ACT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("author count table check failed");

`endif

// ----- sv/act_pkg.sv -----
// Package with the types and constants of the author count table.
`timescale 1ns / 1ps
package act_pkg;

    localparam int ENTRIES_DEF    = 1024;
    localparam int KEY_BYTES_DEF  = 10;
    localparam int COUNT_BITS_DEF = 16;

    // Full key as it arrives: eight head bytes and two tail bytes.
    localparam int KEY_FULL_BITS  = 80;
    localparam int HEAD_BITS      = 64;
    localparam int TAIL_BITS      = 16;
    localparam int OUT_COUNT_BITS = 16;

    localparam int S_DATA_BITS    = 80;
    localparam int M_DATA_BITS    = 24;

    localparam logic OP_FIND = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ----- sv/author_count_table_unit.sv -----
// Top level of the author count table: key lookup by linear scan, count update.
// An item accepted with N entries in use scans up to N entries, one per cycle through
// the read port of the key and count memories, stopping early on a hit, then finishes
// in a decision state, where a find result is loaded into the output once it is free.
// One item at a time: no new item is accepted until the last one is back in idle, and
// a find result waits in the decision state for the output to free up.
// Reset clears the entry count, the overflow flag and the output; memories are not cleared.
`timescale 1ns / 1ps
module author_count_table_unit #(
    parameter int ENTRIES    = act_pkg::ENTRIES_DEF,
    parameter int KEY_BYTES  = act_pkg::KEY_BYTES_DEF,
    parameter int COUNT_BITS = act_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: name_head[63:0], name_tail[79:64].
    input  logic [act_pkg::S_DATA_BITS-1:0] s_axis_tdata,
    // Fields from bit 0: op.
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: count[15:0], overflow[16], zero fill[23:17].
    output logic [act_pkg::M_DATA_BITS-1:0] m_axis_tdata
);

    localparam int KW = KEY_BYTES * 8;
    localparam int UW = $clog2(ENTRIES + 1);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam int OUT_W = act_pkg::OUT_COUNT_BITS;

    // Key and count memories, one entry per stored name.
    logic [KW-1:0]         key_mem [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

    act_pkg::t_state r_state, n_state;

    logic                  r_op;
    logic [KW-1:0]         r_key;
    logic [UW-1:0]         r_used;
    logic                  r_ovf;
    logic [UW-1:0]         r_addr;
    logic                  r_cmp_vld;
    logic [AW-1:0]         r_cmp_idx;
    logic [KW-1:0]         r_key_q;
    logic [COUNT_BITS-1:0] r_cnt_q;
    logic                  r_found;
    logic [AW-1:0]         r_idx;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_out_vld;
    logic [OUT_W-1:0]      r_out_cnt;
    logic                  r_out_ovf;

    logic [act_pkg::KEY_FULL_BITS-1:0] w_key_full;
    logic [KW-1:0]                     w_key_in;
    logic                              w_accept;
    logic                              w_issue;
    logic                              w_hit;
    logic                              w_miss;
    logic                              w_out_free;
    logic                              w_load_out;
    logic                              w_cnt_upd;
    logic                              w_new_entry;
    logic                              w_set_ovf;
    logic [31:0]                       w_cnt_wide;

    assign w_key_full = {s_axis_tdata[act_pkg::HEAD_BITS-1:0],
                         s_axis_tdata[act_pkg::S_DATA_BITS-1:act_pkg::HEAD_BITS]};
    assign w_key_in   = w_key_full[act_pkg::KEY_FULL_BITS-1 -: KW];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_issue    = (r_state == act_pkg::ST_SCAN) && (r_addr < r_used);
    assign w_hit      = (r_state == act_pkg::ST_SCAN) && r_cmp_vld && (r_key_q == r_key);
    assign w_miss     = (r_state == act_pkg::ST_SCAN) && !r_cmp_vld && !w_issue;
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_cnt_wide = 32'(r_cnt);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            act_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = act_pkg::ST_SCAN;
                end
            end
            act_pkg::ST_SCAN: begin
                if (w_hit || w_miss) begin
                    n_state = act_pkg::ST_DONE;
                end
            end
            act_pkg::ST_DONE: begin
                if (r_op == act_pkg::OP_ADD || w_out_free) begin
                    n_state = act_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = act_pkg::ST_IDLE;
            end
        endcase
    end

    // Input ready in the idle state and control strobes of the decision state.
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        w_cnt_upd     = 1'b0;
        w_new_entry   = 1'b0;
        w_set_ovf     = 1'b0;
        unique case (r_state)
            act_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            act_pkg::ST_SCAN: begin
            end
            act_pkg::ST_DONE: begin
                if (r_op == act_pkg::OP_ADD) begin
                    if (r_found) begin
                        w_cnt_upd = 1'b1;
                    end else if (r_used < UW'(ENTRIES)) begin
                        w_new_entry = 1'b1;
                    end else begin
                        w_set_ovf = 1'b1;
                    end
                end else begin
                    w_load_out = w_out_free;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= act_pkg::ST_IDLE;
            r_used    <= '0;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue;
            if (w_new_entry) begin
                r_used <= r_used + UW'(1);
            end
            if (w_set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Scan and payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= s_axis_tuser;
            r_key  <= w_key_in;
            r_addr <= '0;
        end else if (w_issue) begin
            r_addr <= r_addr + UW'(1);
        end
        r_cmp_idx <= r_addr[AW-1:0];
        if (w_hit) begin
            r_found <= 1'b1;
            r_idx   <= r_cmp_idx;
            r_cnt   <= r_cnt_q;
        end else if (w_miss) begin
            r_found <= 1'b0;
        end
        if (w_load_out) begin
            r_out_cnt <= r_found ? w_cnt_wide[OUT_W-1:0] : '0;
            r_out_ovf <= r_ovf;
        end
    end

    // Memory ports: one registered read at the scan address, one write.
    always_ff @(posedge i_clk) begin
        r_key_q <= key_mem[r_addr[AW-1:0]];
        r_cnt_q <= cnt_mem[r_addr[AW-1:0]];
        if (w_new_entry) begin
            key_mem[r_used[AW-1:0]] <= r_key;
            cnt_mem[r_used[AW-1:0]] <= COUNT_BITS'(1);
        end else if (w_cnt_upd && r_cnt != CNT_MAX) begin
            cnt_mem[r_idx] <= r_cnt + COUNT_BITS'(1);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(act_pkg::M_DATA_BITS - OUT_W - 1)'(0), r_out_ovf, r_out_cnt};

endmodule

// ----- sv/act_chk.sv -----
// Port-level checker for the author count table, bound to the top level.
`timescale 1ns / 1ps
`include "author_count_table_unit_defines.svh"
module act_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [act_pkg::M_DATA_BITS-1:0] m_axis_tdata
);

    logic r_seen_ovf;
    logic w_s_accept;
    logic w_m_accept;

    assign w_s_accept = s_axis_tvalid && s_axis_tready;
    assign w_m_accept = m_axis_tvalid && m_axis_tready;

    // Remembers whether any delivered result has reported a dropped add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ovf <= 1'b0;
        end else if (w_m_accept && m_axis_tdata[act_pkg::OUT_COUNT_BITS]) begin
            r_seen_ovf <= 1'b1;
        end
    end

    `ACT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ACT_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `ACT_ASSERT_NEXT(a_busy_after_accept, w_s_accept, !s_axis_tready)
    `ACT_ASSERT_NOW(a_ovf_sticky, m_axis_tvalid && r_seen_ovf, m_axis_tdata[act_pkg::OUT_COUNT_BITS])

endmodule

bind author_count_table_unit act_chk u_act_chk (.*);
